/* src/cnq_pkg.sv */
// Shared types, codes and field widths for the coalescing notify queue.
package cnq_pkg;

  localparam int FUNC_W = 2;
  localparam int DEV_W  = 2;
  localparam int CHAN_W = 4;
  localparam int CNT_W  = 5;
  localparam int STAT_W = 2;
  localparam int OPEN_W = 16;
  localparam int POST_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STOP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd3;

  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_STOPPED  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NOTHING  = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic pop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic go_pop;
    logic pop_last;
  } dp_status_t;

endpackage

/* src/cnq_ctrl.sv */
// Controller state machine: accept, execute one step, then pop a batch when a read has entries to take.
module cnq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  cnq_pkg::dp_status_t   dp_status,
  output logic                  busy,
  output cnq_pkg::ctrl_cmd_t    cmd
);

  cnq_pkg::state_t state_r;
  cnq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cnq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cnq_pkg::ST_IDLE: begin
        if (start) state_nxt = cnq_pkg::ST_EXEC;
      end
      cnq_pkg::ST_EXEC: begin
        state_nxt = dp_status.go_pop ? cnq_pkg::ST_POP : cnq_pkg::ST_IDLE;
      end
      cnq_pkg::ST_POP: begin
        if (dp_status.pop_last) state_nxt = cnq_pkg::ST_IDLE;
      end
      default: state_nxt = cnq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      cnq_pkg::ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      cnq_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      cnq_pkg::ST_POP: begin
        cmd.pop = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

/* src/cnq_datapath.sv */
// Datapath: ring memory, pending flags, open and post counters, result registers.
module cnq_datapath #(
  parameter int DEVICES     = 4,
  parameter int CHANNELS    = 16,
  parameter int QUEUE_DEPTH = 64,
  parameter int MAX_BATCH   = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cnq_pkg::ctrl_cmd_t           cmd,
  output cnq_pkg::dp_status_t          dp_status,
  input  logic [cnq_pkg::FUNC_W-1:0]   in_func,
  input  logic [cnq_pkg::DEV_W-1:0]    in_device_id,
  input  logic [cnq_pkg::CHAN_W-1:0]   in_channel_id,
  input  logic [cnq_pkg::CNT_W-1:0]    in_max_count,
  output logic                         out_valid,
  output logic [cnq_pkg::STAT_W-1:0]   out_status,
  output logic [cnq_pkg::DEV_W-1:0]    out_entry_device,
  output logic [cnq_pkg::CHAN_W-1:0]   out_entry_channel,
  output logic                         out_entry_valid,
  output logic [cnq_pkg::CNT_W-1:0]    out_batch_count,
  output logic                         out_last
);

  localparam int FLAG_COUNT = DEVICES * CHANNELS;
  localparam int FLAG_IDX_W = (FLAG_COUNT > 1) ? $clog2(FLAG_COUNT) : 1;
  localparam int PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int BATCH_W    = $clog2(MAX_BATCH + 1);
  localparam int NW0        = (FILL_W > BATCH_W) ? FILL_W : BATCH_W;
  localparam int NW         = (NW0 > cnq_pkg::CNT_W) ? NW0 : cnq_pkg::CNT_W;
  localparam int ENTRY_W    = cnq_pkg::DEV_W + cnq_pkg::CHAN_W;

  localparam logic signed [cnq_pkg::OPEN_W-1:0] OPEN_MAX = 16'sh7FFF;
  localparam logic signed [cnq_pkg::OPEN_W-1:0] OPEN_MIN = 16'sh8000;

  // latched transaction
  logic [cnq_pkg::FUNC_W-1:0] func_r;
  logic [cnq_pkg::DEV_W-1:0]  dev_r;
  logic [cnq_pkg::CHAN_W-1:0] chan_r;
  logic [cnq_pkg::CNT_W-1:0]  maxc_r;

  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r;
  logic [FILL_W-1:0] fill_r;
  logic [FLAG_COUNT-1:0] flags_r;
  logic signed [cnq_pkg::OPEN_W-1:0] open_r, open_nxt, open_inc, open_dec;
  logic [cnq_pkg::POST_W-1:0] post_r, post_nxt;
  logic [NW-1:0] n_r, k_r, k_inc, n_min1, n_calc;

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [ENTRY_W-1:0] wr_data;

  logic is_start, is_stop, is_report, is_read;
  logic in_range, ring_full, rep_new, enq, stop_post;
  logic read_stopped, read_idle, take_post, go_pop, pop_last, emit, post_sat;
  logic [FLAG_IDX_W-1:0] in_idx, pop_idx;
  logic [cnq_pkg::DEV_W-1:0]  pop_dev;
  logic [cnq_pkg::CHAN_W-1:0] pop_chan;
  logic [cnq_pkg::STAT_W-1:0] exec_status;

  logic                       out_valid_r;
  logic [cnq_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [cnq_pkg::DEV_W-1:0]  out_dev_r, out_dev_nxt;
  logic [cnq_pkg::CHAN_W-1:0] out_chan_r, out_chan_nxt;
  logic                       out_ev_r, out_ev_nxt;
  logic [cnq_pkg::CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic                       out_last_r, out_last_nxt;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= in_func;
      dev_r  <= in_device_id;
      chan_r <= in_channel_id;
      maxc_r <= in_max_count;
    end
  end

  assign is_start  = (func_r == cnq_pkg::FUNC_START);
  assign is_stop   = (func_r == cnq_pkg::FUNC_STOP);
  assign is_report = (func_r == cnq_pkg::FUNC_REPORT);
  assign is_read   = (func_r == cnq_pkg::FUNC_READ);

  assign in_range = (32'(dev_r) < DEVICES) && (32'(chan_r) < CHANNELS);
  assign in_idx   = FLAG_IDX_W'(32'(dev_r) * CHANNELS + 32'(chan_r));

  assign pop_dev  = rd_data_r[ENTRY_W-1:cnq_pkg::CHAN_W];
  assign pop_chan = rd_data_r[cnq_pkg::CHAN_W-1:0];
  assign pop_idx  = FLAG_IDX_W'(32'(pop_dev) * CHANNELS + 32'(pop_chan));

  assign wr_data = {dev_r, chan_r};

  assign open_inc  = (open_r == OPEN_MAX) ? open_r : open_r + 16'sd1;
  assign open_dec  = (open_r == OPEN_MIN) ? open_r : open_r - 16'sd1;
  assign stop_post = (open_dec <= 16'sd0);
  assign post_sat  = (post_r == '1);

  assign ring_full = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign rep_new   = cmd.exec && is_report && in_range && !flags_r[in_idx];
  assign enq       = rep_new && !ring_full;

  assign read_stopped = (open_r <= 16'sd0);
  assign read_idle    = (post_r == '0);
  assign take_post    = cmd.exec && is_read && !read_stopped && !read_idle;

  assign n_min1 = (NW'(maxc_r) < NW'(MAX_BATCH)) ? NW'(maxc_r) : NW'(MAX_BATCH);
  assign n_calc = (n_min1 < NW'(fill_r)) ? n_min1 : NW'(fill_r);
  assign go_pop = is_read && !read_stopped && !read_idle && (n_calc != '0);

  assign k_inc    = k_r + NW'(1);
  assign pop_last = (k_inc == n_r);

  assign dp_status.go_pop   = go_pop;
  assign dp_status.pop_last = pop_last;

  always_comb begin
    head_nxt = head_r;
    if (cmd.pop) begin
      head_nxt = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
    end
  end

  always_comb begin
    open_nxt = open_r;
    post_nxt = post_r;
    if (cmd.exec && is_start) open_nxt = open_inc;
    if (cmd.exec && is_stop) begin
      open_nxt = open_dec;
      if (stop_post && !post_sat) post_nxt = post_r + 16'd1;
    end
    if (enq && !post_sat) post_nxt = post_r + 16'd1;
    if (take_post) post_nxt = post_r - 16'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
      open_r <= '0;
      post_r <= '0;
      n_r    <= '0;
      k_r    <= '0;
    end else begin
      head_r <= head_nxt;
      open_r <= open_nxt;
      post_r <= post_nxt;
      if (enq) begin
        tail_r <= (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
        fill_r <= fill_r + FILL_W'(1);
      end else if (cmd.pop) begin
        fill_r <= fill_r - FILL_W'(1);
      end
      if (cmd.exec) begin
        n_r <= n_calc;
        k_r <= '0;
      end else if (cmd.pop) begin
        k_r <= k_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (cmd.exec && is_stop && in_range) begin
      flags_r[in_idx] <= 1'b0;
    end else if (enq) begin
      flags_r[in_idx] <= 1'b1;
    end else if (cmd.pop) begin
      flags_r[pop_idx] <= 1'b0;
    end
  end

  // Read port follows the next head, so rd_data_r always holds the head entry;
  // a write into that slot in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (enq) mem[tail_r] <= wr_data;
    if (enq && (tail_r == head_nxt)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[head_nxt];
    end
  end

  always_comb begin
    exec_status = cnq_pkg::STATUS_OK;
    if (is_read) begin
      if (read_stopped)   exec_status = cnq_pkg::STATUS_STOPPED;
      else if (read_idle) exec_status = cnq_pkg::STATUS_NOTHING;
    end else if (rep_new && ring_full) begin
      exec_status = cnq_pkg::STATUS_OVERFLOW;
    end
  end

  assign emit = (cmd.exec && !go_pop) || cmd.pop;

  always_comb begin
    if (cmd.pop) begin
      out_status_nxt = cnq_pkg::STATUS_OK;
      out_dev_nxt    = pop_dev;
      out_chan_nxt   = pop_chan;
      out_ev_nxt     = 1'b1;
      out_cnt_nxt    = cnq_pkg::CNT_W'(k_inc);
      out_last_nxt   = pop_last;
    end else begin
      out_status_nxt = exec_status;
      out_dev_nxt    = '0;
      out_chan_nxt   = '0;
      out_ev_nxt     = 1'b0;
      out_cnt_nxt    = '0;
      out_last_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= out_status_nxt;
      out_dev_r    <= out_dev_nxt;
      out_chan_r   <= out_chan_nxt;
      out_ev_r     <= out_ev_nxt;
      out_cnt_r    <= out_cnt_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_entry_device  = out_dev_r;
  assign out_entry_channel = out_chan_r;
  assign out_entry_valid   = out_ev_r;
  assign out_batch_count   = out_cnt_r;
  assign out_last          = out_last_r;

endmodule

/* src/coalescing_notify_queue_unit.sv */
// Top level of the coalescing notify queue: controller plus datapath.
// A command is latched on acceptance and executed in ST_EXEC; a read that pops continues in ST_POP.
// Start, stop, report and status-only reads give one result; busy is high while the command executes.
// A read popping n entries gives n results on consecutive cycles, one entry per cycle from the
// read port of the ring memory; busy stays high until the last pop, so no new command is taken.
// Reset (synchronous, rst_n low) clears pointers, fill, pending flags and both
// counters; ring contents are not cleared. Results cannot be stalled by the receiver.
module coalescing_notify_queue_unit #(
  parameter int DEVICES     = 4,
  parameter int CHANNELS    = 16,
  parameter int QUEUE_DEPTH = 64,
  parameter int MAX_BATCH   = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [cnq_pkg::FUNC_W-1:0]   in_func,
  input  logic [cnq_pkg::DEV_W-1:0]    in_device_id,
  input  logic [cnq_pkg::CHAN_W-1:0]   in_channel_id,
  input  logic [cnq_pkg::CNT_W-1:0]    in_max_count,
  output logic                         out_valid,
  output logic [cnq_pkg::STAT_W-1:0]   out_status,
  output logic [cnq_pkg::DEV_W-1:0]    out_entry_device,
  output logic [cnq_pkg::CHAN_W-1:0]   out_entry_channel,
  output logic                         out_entry_valid,
  output logic [cnq_pkg::CNT_W-1:0]    out_batch_count,
  output logic                         out_last
);

  cnq_pkg::ctrl_cmd_t  cmd;
  cnq_pkg::dp_status_t dp_status;

  cnq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .dp_status (dp_status),
    .busy      (busy),
    .cmd       (cmd)
  );

  cnq_datapath #(
    .DEVICES     (DEVICES),
    .CHANNELS    (CHANNELS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_BATCH   (MAX_BATCH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .dp_status         (dp_status),
    .in_func           (in_func),
    .in_device_id      (in_device_id),
    .in_channel_id     (in_channel_id),
    .in_max_count      (in_max_count),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_entry_device  (out_entry_device),
    .out_entry_channel (out_entry_channel),
    .out_entry_valid   (out_entry_valid),
    .out_batch_count   (out_batch_count),
    .out_last          (out_last)
  );

endmodule

/* src/cnq_checker.sv */
// Port-level checker for the coalescing notify queue, bound to the top level.
module cnq_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [cnq_pkg::STAT_W-1:0] out_status,
  input logic                       out_entry_valid,
  input logic                       out_last
);

  // after acceptance the unit is busy with no result, then there is a result or the batch is still popping
  a_first_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid) ##1 (out_valid || busy))
    else $error("no result and no pop two cycles after accept");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("busy still high with last result");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("batch result without busy");

  a_no_entry_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_entry_valid) |-> out_last)
    else $error("result without entry is not last");

  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_entry_valid) |-> (out_status == cnq_pkg::STATUS_OK))
    else $error("popped entry with non-ok status");

endmodule

bind coalescing_notify_queue_unit cnq_checker u_cnq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_entry_valid (out_entry_valid),
  .out_last        (out_last)
);

/* verif/tb_coalescing_notify_queue_unit.sv */
`timescale 1ns / 100ps
// Testbench for coalescing_notify_queue_unit: directed command table, then random phases.
module tb_coalescing_notify_queue_unit;

  localparam int DEVICES     = 4;
  localparam int CHANNELS    = 16;
  localparam int QUEUE_DEPTH = 64;
  localparam int MAX_BATCH   = 16;
  localparam int FLAG_COUNT  = DEVICES * CHANNELS;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int N_OPEN      = 24;
  localparam int RAND_ITEMS  = 420;
  localparam int LATENCY     = 2;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [cnq_pkg::STAT_W-1:0] status;
    logic [cnq_pkg::DEV_W-1:0]  device;
    logic [cnq_pkg::CHAN_W-1:0] channel;
    logic                       entry_valid;
    logic [cnq_pkg::CNT_W-1:0]  batch_count;
    logic                       last;
  } reply_t;

  typedef struct packed {
    logic [cnq_pkg::DEV_W-1:0]  dev;
    logic [cnq_pkg::CHAN_W-1:0] chan;
  } slot_t;

  typedef struct packed {
    logic [cnq_pkg::FUNC_W-1:0] func;
    logic [cnq_pkg::DEV_W-1:0]  dev;
    logic [cnq_pkg::CHAN_W-1:0] chan;
    logic [cnq_pkg::CNT_W-1:0]  maxc;
    logic                       typed;
    logic [cnq_pkg::STAT_W-1:0] status;
  } cmd_row_t;

  typedef enum int { PH_MIX, PH_FLOOD, PH_DRAIN } phase_kind_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [cnq_pkg::FUNC_W-1:0] in_func = '0;
  logic [cnq_pkg::DEV_W-1:0]  in_device_id = '0;
  logic [cnq_pkg::CHAN_W-1:0] in_channel_id = '0;
  logic [cnq_pkg::CNT_W-1:0]  in_max_count = '0;
  logic                       out_valid;
  logic [cnq_pkg::STAT_W-1:0] out_status;
  logic [cnq_pkg::DEV_W-1:0]  out_entry_device;
  logic [cnq_pkg::CHAN_W-1:0] out_entry_channel;
  logic                       out_entry_valid;
  logic [cnq_pkg::CNT_W-1:0]  out_batch_count;
  logic                       out_last;

  // predictor state
  slot_t                 ring_slot [QUEUE_DEPTH];
  logic [PTR_W-1:0]      head_p = '0;
  logic [PTR_W-1:0]      tail_p = '0;
  int unsigned           fill_n = 0;
  logic [FLAG_COUNT-1:0] flags = '0;
  int                    open_n = 0;
  int unsigned           posts_n = 0;
  reply_t                fresh [$];

  reply_t due_replies [$];
  reply_t want;
  bit     start_up = 1'b0;
  bit     no_idle = 1'b0;
  int     burst_left = 0;
  int     n_errors = 0;
  int     n_items = 0;
  int     n_checked = 0;
  int     n_popped = 0;
  int     n_overflow = 0;
  int     n_stopped = 0;
  int     n_nothing = 0;
  int     cycle_n = 0;

  cmd_row_t opening_rows [N_OPEN];

  coalescing_notify_queue_unit #(
    .DEVICES(DEVICES),
    .CHANNELS(CHANNELS),
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MAX_BATCH(MAX_BATCH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_func(in_func),
    .in_device_id(in_device_id),
    .in_channel_id(in_channel_id),
    .in_max_count(in_max_count),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_entry_device(out_entry_device),
    .out_entry_channel(out_entry_channel),
    .out_entry_valid(out_entry_valid),
    .out_batch_count(out_batch_count),
    .out_last(out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_n,
               due_replies.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic reply_t plain_reply(input logic [cnq_pkg::STAT_W-1:0] st);
    reply_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic logic [cnq_pkg::DEV_W-1:0] rand_dev();
    return cnq_pkg::DEV_W'($urandom_range(0, 3));
  endfunction

  function automatic logic [cnq_pkg::CHAN_W-1:0] rand_chan();
    return cnq_pkg::CHAN_W'($urandom_range(0, 15));
  endfunction

  function automatic logic [cnq_pkg::CNT_W-1:0] rand_maxc();
    return cnq_pkg::CNT_W'($urandom_range(0, 31));
  endfunction

  function automatic logic [cnq_pkg::CNT_W-1:0] mix_maxc();
    if ($urandom_range(0, 3) == 0) return rand_maxc();
    return cnq_pkg::CNT_W'($urandom_range(1, 16));
  endfunction

  function automatic logic [cnq_pkg::CNT_W-1:0] drain_maxc();
    if ($urandom_range(0, 3) == 0) return rand_maxc();
    return cnq_pkg::CNT_W'(MAX_BATCH);
  endfunction

  // Behavior of one transaction on the doorbell queue; replies go to fresh.
  task automatic queue_apply(input logic [cnq_pkg::FUNC_W-1:0] f,
                             input logic [cnq_pkg::DEV_W-1:0] d,
                             input logic [cnq_pkg::CHAN_W-1:0] c,
                             input logic [cnq_pkg::CNT_W-1:0] m);
    int unsigned take;
    int unsigned k;
    bit src_ok;
    slot_t s;
    reply_t r;
    fresh.delete();
    src_ok = (d < DEVICES) && (c < CHANNELS);
    case (f)
      cnq_pkg::FUNC_START: begin
        if (open_n < 32767) open_n++;
        fresh.push_back(plain_reply(cnq_pkg::STATUS_OK));
      end
      cnq_pkg::FUNC_STOP: begin
        if (src_ok) flags[{d, c}] = 1'b0;
        if (open_n > -32768) open_n--;
        if (open_n <= 0 && posts_n < 65535) posts_n++;
        fresh.push_back(plain_reply(cnq_pkg::STATUS_OK));
      end
      cnq_pkg::FUNC_REPORT: begin
        if (!src_ok || flags[{d, c}]) begin
          fresh.push_back(plain_reply(cnq_pkg::STATUS_OK));
        end else if (fill_n >= QUEUE_DEPTH) begin
          n_overflow++;
          fresh.push_back(plain_reply(cnq_pkg::STATUS_OVERFLOW));
        end else begin
          flags[{d, c}] = 1'b1;
          ring_slot[tail_p] = '{dev: d, chan: c};
          tail_p = (tail_p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_p + PTR_W'(1);
          fill_n++;
          if (posts_n < 65535) posts_n++;
          fresh.push_back(plain_reply(cnq_pkg::STATUS_OK));
        end
      end
      default: begin
        if (open_n <= 0) begin
          n_stopped++;
          fresh.push_back(plain_reply(cnq_pkg::STATUS_STOPPED));
        end else if (posts_n == 0) begin
          n_nothing++;
          fresh.push_back(plain_reply(cnq_pkg::STATUS_NOTHING));
        end else begin
          posts_n--;
          take = 32'(m);
          if (take > MAX_BATCH) take = MAX_BATCH;
          if (take > fill_n) take = fill_n;
          if (take == 0) fresh.push_back(plain_reply(cnq_pkg::STATUS_OK));
          for (k = 1; k <= take; k++) begin
            s = ring_slot[head_p];
            head_p = (head_p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_p + PTR_W'(1);
            fill_n--;
            flags[{s.dev, s.chan}] = 1'b0;
            r = '0;
            r.status = cnq_pkg::STATUS_OK;
            r.device = s.dev;
            r.channel = s.chan;
            r.entry_valid = 1'b1;
            r.batch_count = cnq_pkg::CNT_W'(k);
            r.last = (k == take);
            fresh.push_back(r);
            n_popped++;
          end
        end
      end
    endcase
  endtask

  // Drive one command, wait for the handshake, then queue what it owes.
  task automatic issue(input logic [cnq_pkg::FUNC_W-1:0] f,
                       input logic [cnq_pkg::DEV_W-1:0] d,
                       input logic [cnq_pkg::CHAN_W-1:0] c,
                       input logic [cnq_pkg::CNT_W-1:0] m,
                       input logic typed, input logic [cnq_pkg::STAT_W-1:0] typed_status);
    in_func <= f;
    in_device_id <= d;
    in_channel_id <= c;
    in_max_count <= m;
    start <= 1'b1;
    start_up = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    queue_apply(f, d, c, m);
    if (typed) due_replies.push_back(plain_reply(typed_status));
    else foreach (fresh[i]) due_replies.push_back(fresh[i]);
    n_items++;
  endtask

  task automatic lower_start();
    if (start_up) begin
      start <= 1'b0;
      start_up = 1'b0;
    end
  endtask

  task automatic pace();
    int gap;
    if (no_idle) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 12);
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      lower_start();
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    lower_start();
    do @(posedge clk); while (due_replies.size() != 0);
  endtask

  // reply checker
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (due_replies.size() == 0) begin
        $error("reply with nothing expected: status %0d dev %0d chan %0d", out_status,
               out_entry_device, out_entry_channel);
        n_errors++;
      end else begin
        want = due_replies.pop_front();
        n_checked++;
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          n_errors++;
        end
        if (out_entry_device !== want.device) begin
          $error("entry_device: expected %0d, got %0d", want.device, out_entry_device);
          n_errors++;
        end
        if (out_entry_channel !== want.channel) begin
          $error("entry_channel: expected %0d, got %0d", want.channel, out_entry_channel);
          n_errors++;
        end
        if (out_entry_valid !== want.entry_valid) begin
          $error("entry_valid: expected %0d, got %0d", want.entry_valid, out_entry_valid);
          n_errors++;
        end
        if (out_batch_count !== want.batch_count) begin
          $error("batch_count: expected %0d, got %0d", want.batch_count, out_batch_count);
          n_errors++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          n_errors++;
        end
      end
    end
  end

  initial begin
    int i, j, t, reps, phase_no;
    int order [FLAG_COUNT];
    int r;
    phase_kind_t kind;
    logic [cnq_pkg::FUNC_W-1:0] f;

    // typed status only where it is obvious from the state at that point
    opening_rows = '{
      // nothing open after reset
      '{cnq_pkg::FUNC_READ,   2'd0, 4'd0,  5'd16, 1'b1, cnq_pkg::STATUS_STOPPED},
      '{cnq_pkg::FUNC_START,  2'd0, 4'd0,  5'd1,  1'b1, cnq_pkg::STATUS_OK},
      // open but no post
      '{cnq_pkg::FUNC_READ,   2'd0, 4'd0,  5'd16, 1'b1, cnq_pkg::STATUS_NOTHING},
      '{cnq_pkg::FUNC_REPORT, 2'd3, 4'd15, 5'd1,  1'b1, cnq_pkg::STATUS_OK},
      // coalesced, flag set
      '{cnq_pkg::FUNC_REPORT, 2'd3, 4'd15, 5'd1,  1'b1, cnq_pkg::STATUS_OK},
      '{cnq_pkg::FUNC_REPORT, 2'd0, 4'd0,  5'd1,  1'b1, cnq_pkg::STATUS_OK},
      '{cnq_pkg::FUNC_REPORT, 2'd2, 4'd10, 5'd1,  1'b1, cnq_pkg::STATUS_OK},
      '{cnq_pkg::FUNC_READ,   2'd0, 4'd0,  5'd1,  1'b0, cnq_pkg::STATUS_OK},
      // re-queued after pop
      '{cnq_pkg::FUNC_REPORT, 2'd3, 4'd15, 5'd1,  1'b0, cnq_pkg::STATUS_OK},
      // zero max_count eats post
      '{cnq_pkg::FUNC_READ,   2'd0, 4'd0,  5'd0,  1'b0, cnq_pkg::STATUS_OK},
      // clamps to MAX_BATCH, then to the ring fill
      '{cnq_pkg::FUNC_READ,   2'd3, 4'd15, 5'd31, 1'b0, cnq_pkg::STATUS_OK},
      // post left, ring empty
      '{cnq_pkg::FUNC_READ,   2'd0, 4'd0,  5'd16, 1'b0, cnq_pkg::STATUS_OK},
      '{cnq_pkg::FUNC_READ,   2'd0, 4'd0,  5'd16, 1'b1, cnq_pkg::STATUS_NOTHING},
      '{cnq_pkg::FUNC_REPORT, 2'd1, 4'd5,  5'd16, 1'b1, cnq_pkg::STATUS_OK},
      // open drops to zero, posts
      '{cnq_pkg::FUNC_STOP,   2'd1, 4'd5,  5'd16, 1'b1, cnq_pkg::STATUS_OK},
      '{cnq_pkg::FUNC_READ,   2'd1, 4'd5,  5'd16, 1'b1, cnq_pkg::STATUS_STOPPED},
      // open goes negative
      '{cnq_pkg::FUNC_STOP,   2'd0, 4'd3,  5'd0,  1'b1, cnq_pkg::STATUS_OK},
      '{cnq_pkg::FUNC_START,  2'd2, 4'd9,  5'd0,  1'b1, cnq_pkg::STATUS_OK},
      '{cnq_pkg::FUNC_START,  2'd1, 4'd6,  5'd16, 1'b1, cnq_pkg::STATUS_OK},
      // second copy in ring
      '{cnq_pkg::FUNC_REPORT, 2'd1, 4'd5,  5'd16, 1'b0, cnq_pkg::STATUS_OK},
      '{cnq_pkg::FUNC_READ,   2'd2, 4'd10, 5'd16, 1'b0, cnq_pkg::STATUS_OK},
      '{cnq_pkg::FUNC_READ,   2'd0, 4'd0,  5'd2,  1'b0, cnq_pkg::STATUS_OK},
      '{cnq_pkg::FUNC_STOP,   2'd1, 4'd10, 5'd16, 1'b1, cnq_pkg::STATUS_OK},
      '{cnq_pkg::FUNC_START,  2'd3, 4'd15, 5'd31, 1'b1, cnq_pkg::STATUS_OK}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_OPEN; i++) begin
      issue(opening_rows[i].func, opening_rows[i].dev, opening_rows[i].chan,
            opening_rows[i].maxc, opening_rows[i].typed, opening_rows[i].status);
      pace();
    end
    drain();

    phase_no = 0;
    while (n_items < N_OPEN + RAND_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if (phase_no % 3 == 1) kind = PH_FLOOD;
      else kind = $urandom_range(0, 1) ? PH_MIX : PH_DRAIN;
      case (kind)
        PH_MIX: begin
          reps = $urandom_range(20, 50);
          for (i = 0; i < reps; i++) begin
            r = $urandom_range(0, 99);
            if (r < 20) f = cnq_pkg::FUNC_START;
            else if (r < 30) f = cnq_pkg::FUNC_STOP;
            else if (r < 72) f = cnq_pkg::FUNC_REPORT;
            else f = cnq_pkg::FUNC_READ;
            issue(f, rand_dev(), rand_chan(), mix_maxc(), 1'b0, cnq_pkg::STATUS_OK);
            pace();
          end
        end
        PH_FLOOD: begin
          // every source once in shuffled order, with stops freeing flags so the
          // ring can fill to its depth and further reports get dropped
          for (i = 0; i < FLAG_COUNT; i++) order[i] = i;
          for (i = FLAG_COUNT - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
          end
          for (i = 0; i < FLAG_COUNT; i++) begin
            issue(cnq_pkg::FUNC_REPORT, cnq_pkg::DEV_W'(order[i] / CHANNELS),
                  cnq_pkg::CHAN_W'(order[i] % CHANNELS), rand_maxc(), 1'b0,
                  cnq_pkg::STATUS_OK);
            pace();
            if ($urandom_range(0, 9) == 0) begin
              issue(cnq_pkg::FUNC_STOP, rand_dev(), rand_chan(), rand_maxc(), 1'b0,
                    cnq_pkg::STATUS_OK);
              pace();
            end
          end
          for (i = 0; i < 4; i++) begin
            issue(cnq_pkg::FUNC_REPORT, rand_dev(), rand_chan(), rand_maxc(), 1'b0,
                  cnq_pkg::STATUS_OK);
            pace();
          end
        end
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            while (open_n > 0) begin
              issue(cnq_pkg::FUNC_STOP, rand_dev(), rand_chan(), rand_maxc(), 1'b0,
                    cnq_pkg::STATUS_OK);
              pace();
            end
            issue(cnq_pkg::FUNC_READ, rand_dev(), rand_chan(), rand_maxc(), 1'b0,
                  cnq_pkg::STATUS_OK);
            pace();
          end
          while (open_n <= 0) begin
            issue(cnq_pkg::FUNC_START, rand_dev(), rand_chan(), rand_maxc(), 1'b0,
                  cnq_pkg::STATUS_OK);
            pace();
          end
          reps = 0;
          while (fill_n > 0 && reps < 12) begin
            issue(cnq_pkg::FUNC_READ, rand_dev(), rand_chan(), drain_maxc(), 1'b0,
                  cnq_pkg::STATUS_OK);
            pace();
            reps++;
          end
        end
      endcase
      if ($urandom_range(0, 2) == 0) drain();
      phase_no++;
    end

    drain();
    repeat (LATENCY + 4) @(posedge clk);
    $display("%0d commands over %0d phases, %0d replies checked, %0d entries popped",
             n_items, phase_no, n_checked, n_popped);
    $display("%0d reports dropped on a full ring, %0d reads while stopped, %0d with no post",
             n_overflow, n_stopped, n_nothing);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
